[hdl/tpsfp_pkg.sv]
// tpsfp_pkg: shared types and constants for the three-phase serial frame parser
// used by tpsfp_window and three_phase_serial_frame_parser; no dependencies
package tpsfp_pkg;

	// window geometry and frame lengths
	localparam int WIN_DEPTH = 20;
	localparam int WAVE_LEN  = 16;
	localparam int CTRL_LEN  = 20;
	localparam int FILL_W    = $clog2(WIN_DEPTH + 1);
	localparam int IDX_W     = $clog2(WIN_DEPTH);
	localparam int VAL_W     = 17;
	localparam int TOTAL_W   = 32;
	localparam int CNT_BITS_DEF = 32;

	// frame marker bytes
	localparam logic [7:0] HDR_WAVE0  = 8'hFF;
	localparam logic [7:0] HDR_WAVE1  = 8'hCC;
	localparam logic [7:0] HDR_CTRL   = 8'hAA;
	localparam logic [7:0] SUB_VOLT   = 8'hF0;
	localparam logic [7:0] SUB_CURR   = 8'hF1;

	// frame kinds as reported on the result
	localparam logic KIND_WAVE = 1'b0;
	localparam logic KIND_CTRL = 1'b1;

	typedef logic [WIN_DEPTH-1:0][7:0] win_t;
	typedef logic signed [VAL_W-1:0] val_t;

	// window operations issued by the sequencer
	typedef enum logic [2:0] {
		WOP_NONE,
		WOP_PUSH,
		WOP_DROP1,
		WOP_DROPWAVE,
		WOP_CLEAR
	} win_op_t;

	typedef struct packed {
		win_op_t    op;
		logic [7:0] data;
	} win_cmd_t;

	typedef struct packed {
		logic [FILL_W-1:0] fill;
		logic              full;
	} win_stat_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_HEAD,
		S_SUM,
		S_CHECK,
		S_DONE
	} state_t;

endpackage

[hdl/tpsfp_window.sv]
// tpsfp_window: 20-byte receive window with fill count, push, head drops and clear
// depends on tpsfp_pkg
module tpsfp_window
	import tpsfp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  win_cmd_t  cmd,
	output win_t      win,
	output win_stat_t stat
);

	win_t              win_q;
	logic [FILL_W-1:0] fill_q;
	logic              full;

	assign full = (fill_q == FILL_W'(WIN_DEPTH));

	// byte storage, contents above the fill count are don't-care
	always_ff @(posedge clk) begin
		case (cmd.op)
			WOP_PUSH: begin
				if (full) begin
					for (int i = 0; i < WIN_DEPTH - 1; i++) begin
						win_q[i] <= win_q[i+1];
					end
					win_q[WIN_DEPTH-1] <= cmd.data;
				end else begin
					win_q[fill_q[IDX_W-1:0]] <= cmd.data;
				end
			end
			WOP_DROP1: begin
				for (int i = 0; i < WIN_DEPTH - 1; i++) begin
					win_q[i] <= win_q[i+1];
				end
			end
			WOP_DROPWAVE: begin
				for (int i = 0; i < WIN_DEPTH - WAVE_LEN; i++) begin
					win_q[i] <= win_q[i+WAVE_LEN];
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else begin
			case (cmd.op)
				WOP_PUSH:     if (!full) fill_q <= fill_q + 1'b1;
				WOP_DROP1:    fill_q <= fill_q - 1'b1;
				WOP_DROPWAVE: fill_q <= fill_q - FILL_W'(WAVE_LEN);
				WOP_CLEAR:    fill_q <= '0;
				default: ;
			endcase
		end
	end

	assign win       = win_q;
	assign stat.fill = fill_q;
	assign stat.full = full;

endmodule

[hdl/three_phase_serial_frame_parser.sv]
// three_phase_serial_frame_parser: top level of the serial frame parser
// depends on tpsfp_pkg and tpsfp_window
//
// Takes one received serial byte per input transfer and returns exactly one
// result transfer per byte. Bytes collect in a 20-byte window that is scanned
// from its head after every byte: wave frames (FF CC, 16 bytes, big-endian
// byte-sum) yield six signed values; control frames (AA, 20 bytes,
// little-endian sum) with subtype F0/F1 load the held voltages/currents and
// yield all six held values. A bad header or checksum drops one byte and the
// scan repeats. Values are raw (0.1 V and 0.01 A units). The parsed and
// dropped totals saturate at 2^COUNTER_BITS-1 and show their low 32 bits.
// Timing: one shared 16-bit adder forms the checksum one window byte per
// cycle under a small sequencer, and in_stall stays high while a byte is being
// worked. A byte passes through accept, head look and result, plus a head look
// and drop per plainly dropped head byte, plus a head look, checksum pass
// and check per wave or control frame check. The result sits in an output
// register, so the next byte is taken while a result still waits on out_stall.
module three_phase_serial_frame_parser
	import tpsfp_pkg::*;
#(
	parameter int COUNTER_BITS = CNT_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// byte input channel
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [7:0]                rx_byte,
	// result channel
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic                      sample_valid,
	output logic                      frame_kind,
	output logic signed [VAL_W-1:0]   volt_a,
	output logic signed [VAL_W-1:0]   volt_b,
	output logic signed [VAL_W-1:0]   volt_c,
	output logic signed [VAL_W-1:0]   curr_a,
	output logic signed [VAL_W-1:0]   curr_b,
	output logic signed [VAL_W-1:0]   curr_c,
	output logic [TOTAL_W-1:0]        parsed_total,
	output logic [TOTAL_W-1:0]        dropped_total
);

	localparam logic [IDX_W-1:0] WAVE_LAST = IDX_W'(WAVE_LEN - 3);
	localparam logic [IDX_W-1:0] CTRL_LAST = IDX_W'(CTRL_LEN - 3);

	state_t state_q, state_nxt;

	win_cmd_t  win_cmd;
	win_t      win;
	win_stat_t win_stat;

	// checksum engine
	logic [15:0]      sum_q;
	logic [IDX_W-1:0] idx_q;
	logic             kind_q;
	logic [7:0]       rd_byte;
	logic             sum_last;

	// frame decision
	logic wave_ok, ctrl_ok, frame_ok, ctrl_load;
	val_t held_q  [6];
	val_t held_nxt[6];
	val_t wave_val[6];

	// working result
	logic res_have_q, res_kind_q;
	val_t res_val_q[6];

	// counters
	logic [COUNTER_BITS-1:0] parsed_q, dropped_q;

	// sequencer outputs
	logic accept, start_sum, sum_step, bump_drop, bump_parse, take_wave, take_ctrl;
	logic out_load;
	logic out_valid_q;

	tpsfp_window u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (win_cmd),
		.win    (win),
		.stat   (win_stat)
	);

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	// one byte per cycle into the shared adder
	assign rd_byte  = win[idx_q];
	assign sum_last = (idx_q == (kind_q == KIND_CTRL ? CTRL_LAST : WAVE_LAST));

	// checksum and header checks
	assign wave_ok = (win[1] == HDR_WAVE1) && (win[WAVE_LEN-2] == sum_q[15:8])
		&& (win[WAVE_LEN-1] == sum_q[7:0]);
	assign ctrl_ok = (win[CTRL_LEN-2] == sum_q[7:0]) && (win[CTRL_LEN-1] == sum_q[15:8]);
	assign frame_ok  = (kind_q == KIND_CTRL) ? ctrl_ok : wave_ok;
	assign ctrl_load = (win[1] == SUB_VOLT) || (win[1] == SUB_CURR);

	// field extraction
	always_comb begin
		for (int i = 0; i < 6; i++) begin
			wave_val[i] = {win[2+2*i][7], win[2+2*i], win[3+2*i]};
			held_nxt[i] = held_q[i];
		end
		for (int i = 0; i < 3; i++) begin
			if (win[1] == SUB_VOLT) begin
				held_nxt[i] = {1'b0, win[7+2*i], win[6+2*i]};
			end else begin
				held_nxt[3+i] = {1'b0, win[7+2*i], win[6+2*i]};
			end
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) state_nxt = S_HEAD;
			end
			S_HEAD: begin
				if (win_stat.fill == '0) begin
					state_nxt = S_DONE;
				end else if (win[0] == HDR_WAVE0) begin
					state_nxt = (win_stat.fill < FILL_W'(WAVE_LEN)) ? S_DONE : S_SUM;
				end else if (win[0] == HDR_CTRL) begin
					state_nxt = (win_stat.fill < FILL_W'(CTRL_LEN)) ? S_DONE : S_SUM;
				end
			end
			S_SUM: begin
				if (sum_last) state_nxt = S_CHECK;
			end
			S_CHECK: state_nxt = S_HEAD;
			S_DONE: begin
				if (out_load) state_nxt = S_IDLE;
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		win_cmd.op   = WOP_NONE;
		win_cmd.data = rx_byte;
		start_sum    = 1'b0;
		sum_step     = 1'b0;
		bump_drop    = 1'b0;
		bump_parse   = 1'b0;
		take_wave    = 1'b0;
		take_ctrl    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					win_cmd.op = WOP_PUSH;
					// a full window loses its oldest byte
					bump_drop  = win_stat.full;
				end
			end
			S_HEAD: begin
				if (win_stat.fill != '0) begin
					if (win[0] == HDR_WAVE0 || win[0] == HDR_CTRL) begin
						start_sum = 1'b1;
					end else begin
						win_cmd.op = WOP_DROP1;
						bump_drop  = 1'b1;
					end
				end
			end
			S_SUM: sum_step = 1'b1;
			S_CHECK: begin
				if (!frame_ok) begin
					win_cmd.op = WOP_DROP1;
					bump_drop  = 1'b1;
				end else if (kind_q == KIND_CTRL) begin
					win_cmd.op = WOP_CLEAR;
					bump_parse = 1'b1;
					take_ctrl  = ctrl_load;
				end else begin
					win_cmd.op = WOP_DROPWAVE;
					bump_parse = 1'b1;
					take_wave  = 1'b1;
				end
			end
			S_DONE: ;
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			parsed_q    <= '0;
			dropped_q   <= '0;
			res_have_q  <= 1'b0;
			res_kind_q  <= KIND_WAVE;
			for (int i = 0; i < 6; i++) begin
				held_q[i]    <= '0;
				res_val_q[i] <= '0;
			end
		end else begin
			state_q <= state_nxt;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			// saturating counters
			if (bump_drop && dropped_q != '1) dropped_q <= dropped_q + 1'b1;
			if (bump_parse && parsed_q != '1) parsed_q <= parsed_q + 1'b1;
			// a new byte starts with an empty result
			if (accept) begin
				res_have_q <= 1'b0;
				res_kind_q <= KIND_WAVE;
				for (int i = 0; i < 6; i++) res_val_q[i] <= '0;
			end
			if (take_wave) begin
				res_have_q <= 1'b1;
				res_kind_q <= KIND_WAVE;
				for (int i = 0; i < 6; i++) res_val_q[i] <= wave_val[i];
			end
			if (take_ctrl) begin
				res_have_q <= 1'b1;
				res_kind_q <= KIND_CTRL;
				for (int i = 0; i < 6; i++) begin
					res_val_q[i] <= held_nxt[i];
					held_q[i]    <= held_nxt[i];
				end
			end
		end
	end

	// checksum accumulator
	always_ff @(posedge clk) begin
		if (start_sum) begin
			sum_q  <= '0;
			idx_q  <= '0;
			kind_q <= (win[0] == HDR_CTRL) ? KIND_CTRL : KIND_WAVE;
		end else if (sum_step) begin
			sum_q <= sum_q + {8'h00, rd_byte};
			idx_q <= idx_q + 1'b1;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (out_load) begin
			sample_valid  <= res_have_q;
			frame_kind    <= res_kind_q;
			volt_a        <= res_val_q[0];
			volt_b        <= res_val_q[1];
			volt_c        <= res_val_q[2];
			curr_a        <= res_val_q[3];
			curr_b        <= res_val_q[4];
			curr_c        <= res_val_q[5];
			parsed_total  <= TOTAL_W'(parsed_q);
			dropped_total <= TOTAL_W'(dropped_q);
		end
	end

	assign out_valid = out_valid_q;

endmodule
